// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, sizes and codes of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CELL_W  = 16;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic [7:0] ATTR_RESET = 8'd7;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [1:0] {
		KIND_PRINT  = 2'd0,
		KIND_SETPOS = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		cell_t wr_data;
		addr_t rd_addr;
		logic  clear;
		logic  scroll;
		cell_t blank;
	} store_cmd_t;

	typedef struct packed {
		logic  busy;
		cell_t rd_data;
	} store_stat_t;

	function automatic addr_t cell_addr(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		cell_addr = addr_t'(r) * addr_t'(COLUMNS) + addr_t'(c);
	endfunction

endpackage

`default_nettype wire

// File: design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Request and response channels of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [7:0]        character;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;

	modport source (output valid, kind, character, col, row, input ready);
	modport sink (input valid, kind, character, col, row, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [CELL_W-1:0] cell_data;
	logic              scrolled;

	modport source (output valid, cursor_col, cursor_row, cell_data, scrolled, input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_data, scrolled, output ready);
endinterface

`default_nettype wire

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: cursor control, command sequencer and screen store.
// ----------------------------------------------------------------------------
// Print without scroll and set-position go straight to the result state; a read passes through ST_READ first.
// Scroll and clear wait in ST_BUSY while the store sweeps the screen,
// through the single write port of the screen memory, one cell per cycle.
// One item in flight; the result register lets the next transfer start early.
// After reset the screen memory is zeroed before the first request transfer;
// attribute resets to 7, cursor to the origin.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_READ   = 4'b0010,
		ST_BUSY   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t           state_q;
	logic [7:0]       attr_q;
	logic [COL_W-1:0] cur_x_q;
	logic [ROW_W-1:0] cur_y_q;
	cell_t            data_q;
	logic             scroll_q;
	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	cell_t            out_data_q;
	logic             out_scroll_q;

	store_cmd_t       cmd;
	store_stat_t      stat;

	logic             accept;
	logic             out_free;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic [COL_W:0]   px;
	logic [ROW_W:0]   py;
	logic [COL_W-1:0] nx;
	logic [ROW_W-1:0] ny;
	logic             do_write;
	logic             do_scroll;

	assign req.ready = (state_q == ST_IDLE) && !stat.busy;
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign col_c = (req.col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : req.col;
	assign row_c = (req.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req.row;

	always_comb begin
		px       = {1'b0, cur_x_q};
		py       = {1'b0, cur_y_q};
		do_write = 1'b0;
		case (req.character)
			CH_NEWLINE: begin
				px = '0;
				py = py + 1'b1;
			end
			CH_RETURN: px = '0;
			CH_BACKSPACE: begin
				if (cur_x_q == '0) begin
					if (cur_y_q != '0) begin
						px = (COL_W + 1)'(COLUMNS - 1);
						py = py - 1'b1;
					end
				end else begin
					px = px - 1'b1;
				end
			end
			default: begin
				do_write = 1'b1;
				px       = px + 1'b1;
			end
		endcase
		if (px >= (COL_W + 1)'(COLUMNS)) begin
			px = '0;
			py = py + 1'b1;
		end
		do_scroll = 1'b0;
		if (py >= (ROW_W + 1)'(ROWS)) begin
			py        = (ROW_W + 1)'(ROWS - 1);
			do_scroll = 1'b1;
		end
		nx = px[COL_W-1:0];
		ny = py[ROW_W-1:0];
	end

	always_comb begin
		cmd         = '0;
		cmd.wr_addr = cell_addr(cur_y_q, cur_x_q);
		cmd.wr_data = {attr_q, req.character};
		cmd.rd_addr = cell_addr(row_c, col_c);
		cmd.blank   = {attr_q, CH_SPACE};
		if (accept) begin
			unique case (req.kind) inside
				KIND_PRINT: begin
					cmd.wr_en  = do_write;
					cmd.scroll = do_scroll;
				end
				KIND_CLEAR:  cmd.clear = 1'b1;
				KIND_SETPOS, KIND_READ: ;
				default: ;
			endcase
		end
	end

	tcw_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			attr_q      <= ATTR_RESET;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.kind)
							KIND_PRINT: begin
								cur_x_q <= nx;
								cur_y_q <= ny;
								state_q <= do_scroll ? ST_BUSY : ST_RESULT;
							end
							KIND_SETPOS: begin
								cur_x_q <= col_c;
								cur_y_q <= row_c;
								state_q <= ST_RESULT;
							end
							KIND_CLEAR: state_q <= ST_BUSY;
							KIND_READ:  state_q <= ST_READ;
							default:    state_q <= ST_RESULT;
						endcase
					end
				end
				ST_READ: state_q <= ST_RESULT;
				ST_BUSY: begin
					if (!stat.busy) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q   <= '0;
			scroll_q <= (req.kind == KIND_PRINT) && do_scroll;
		end
		if (state_q == ST_READ) begin
			data_q <= stat.rd_data;
		end
		if (state_q == ST_RESULT && out_free) begin
			out_col_q    <= cur_x_q;
			out_row_q    <= cur_y_q;
			out_data_q   <= data_q;
			out_scroll_q <= scroll_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cell_data  = out_data_q;
	assign rsp.scrolled   = out_scroll_q;

endmodule

`default_nettype wire

// File: design/tcw_store.sv
// ----------------------------------------------------------------------------
// tcw_store
// Screen memory with a sweep engine for the reset clear, clear and scroll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_store
	import tcw_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  store_cmd_t  cmd,
	output store_stat_t stat
);

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_COPY = 4'b0100,
		S_FILL = 4'b1000
	} sstate_t;

	sstate_t state_q;
	addr_t   ptr_q;
	addr_t   src_q;
	cell_t   fill_q;
	logic    pend_s1;
	addr_t   dst_s1;
	cell_t   rd_data_q;
	cell_t   mem_q [CELLS];

	logic  we;
	addr_t wa;
	cell_t wd;
	addr_t ra;

	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = fill_q;
		if (pend_s1) begin
			we = 1'b1;
			wa = dst_s1;
			wd = rd_data_q;
		end else if (state_q == S_INIT || state_q == S_FILL) begin
			we = 1'b1;
		end else if (state_q == S_IDLE && cmd.wr_en) begin
			we = 1'b1;
			wa = cmd.wr_addr;
			wd = cmd.wr_data;
		end
		ra = (state_q == S_COPY) ? src_q : cmd.rd_addr;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_data_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ptr_q   <= '0;
			src_q   <= '0;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
			dst_s1  <= '0;
		end else begin
			pend_s1 <= (state_q == S_COPY);
			dst_s1  <= src_q - addr_t'(COLUMNS);
			unique case (state_q) inside
				S_INIT, S_FILL: begin
					if (!pend_s1) begin
						ptr_q <= ptr_q + addr_t'(1);
						if (ptr_q == addr_t'(CELLS - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					fill_q <= cmd.blank;
					if (cmd.clear) begin
						ptr_q   <= '0;
						state_q <= S_FILL;
					end else if (cmd.scroll) begin
						src_q   <= addr_t'(COLUMNS);
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					src_q <= src_q + addr_t'(1);
					if (src_q == addr_t'(CELLS - 1)) begin
						ptr_q   <= addr_t'(CELLS - COLUMNS);
						state_q <= S_FILL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy    = (state_q != S_IDLE) || pend_s1;
	assign stat.rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Text console writer testbench. A directed script covers the reset state,
// clamping, row wrap, backspace at the row start and the origin, scrolling,
// clear and reads. Random traffic across several attribute settings follows.
// Each response transfer is checked against the expected report in the script or, where the
// script gives none, against a cycle-free model of the screen and cursor that this bench keeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import tcw_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN       = 50;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} report_t;

	typedef struct packed {
		logic             is_cfg;
		logic [7:0]       attr;
		kind_t            kind;
		logic [7:0]       ch;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             typed;
		report_t          want;
	} step_row_t;

	localparam int SCRIPT_LEN = 26;
	localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd0,   5'd0,  1'b1, '{7'd0,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd127, 5'd31, 1'b1, '{7'd0,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  8'h41,       7'd0,   5'd0,  1'b1, '{7'd1,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd0,   5'd0,  1'b1, '{7'd1,  5'd0,  16'h0741, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  CH_BACKSPACE, 7'd0,  5'd0,  1'b1, '{7'd0,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  CH_BACKSPACE, 7'd0,  5'd0,  1'b1, '{7'd0,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  8'h00,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_PRINT,  8'hFF,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_PRINT,  CH_RETURN,   7'd0,   5'd0,  1'b1, '{7'd0,  5'd0,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_SETPOS, 8'h00,       7'd127, 5'd31, 1'b1, '{7'd79, 5'd24, 16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  8'h5A,       7'd0,   5'd0,  1'b1, '{7'd0,  5'd24, 16'h0000, 1'b1}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd79,  5'd23, 1'b1, '{7'd0,  5'd24, 16'h075A, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd0,   5'd24, 1'b1, '{7'd0,  5'd24, 16'h0720, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_PRINT,  CH_BACKSPACE, 7'd0,  5'd0,  1'b1, '{7'd79, 5'd23, 16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  CH_NEWLINE,  7'd0,   5'd0,  1'b1, '{7'd0,  5'd24, 16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_PRINT,  CH_NEWLINE,  7'd0,   5'd0,  1'b1, '{7'd0,  5'd24, 16'h0000, 1'b1}},
		'{1'b1, 8'hFF, KIND_PRINT,  8'h00,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_CLEAR,  8'h00,       7'd0,   5'd0,  1'b1, '{7'd0,  5'd24, 16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd40,  5'd12, 1'b1, '{7'd0,  5'd24, 16'hFF20, 1'b0}},
		'{1'b1, 8'h00, KIND_PRINT,  8'h00,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_PRINT,  8'h78,       7'd0,   5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd0,   5'd24, 1'b1, '{7'd1,  5'd24, 16'h0078, 1'b0}},
		'{1'b0, 8'h00, KIND_SETPOS, 8'h00,       7'd79,  5'd0,  1'b0, '0},
		'{1'b0, 8'h00, KIND_PRINT,  8'h71,       7'd0,   5'd0,  1'b1, '{7'd0,  5'd1,  16'h0000, 1'b0}},
		'{1'b0, 8'h00, KIND_READ,   8'h00,       7'd80,  5'd0,  1'b1, '{7'd0,  5'd1,  16'h0071, 1'b0}}
	};

	localparam logic [7:0] PHASE_ATTR [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hC3};
	localparam int         PHASE_GAP  [PHASES] = '{30, 60, 10, 30, 0};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cell_t      screen [CELLS];
	int         csr_x;
	int         csr_y;
	logic [7:0] attr_byte;
	int         gap_pct = 30;
	int         mismatches = 0;
	int         cycle_count;
	report_t    pending_reports [$];

	function automatic report_t console_step(input kind_t k, input logic [7:0] c,
		input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
		report_t r;
		int      px;
		int      py;
		cell_t   blank;
		r = '0;
		px = (int'(x) > COLUMNS - 1) ? COLUMNS - 1 : int'(x);
		py = (int'(y) > ROWS - 1) ? ROWS - 1 : int'(y);
		blank = {attr_byte, CH_SPACE};
		case (k)
			KIND_PRINT: begin
				if (c == CH_NEWLINE) begin
					csr_y++;
					csr_x = 0;
				end else if (c == CH_RETURN) begin
					csr_x = 0;
				end else if (c == CH_BACKSPACE) begin
					if (csr_x == 0) begin
						if (csr_y != 0) begin
							csr_x = COLUMNS - 1;
							csr_y--;
						end
					end else begin
						csr_x--;
					end
				end else begin
					screen[csr_y * COLUMNS + csr_x] = {attr_byte, c};
					csr_x++;
				end
				if (csr_x >= COLUMNS) begin
					csr_x = 0;
					csr_y++;
				end
				if (csr_y >= ROWS) begin
					for (int i = 0; i + COLUMNS < CELLS; i++)
						screen[i] = screen[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						screen[i] = blank;
					csr_y = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			KIND_SETPOS: begin
				csr_x = px;
				csr_y = py;
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = blank;
			end
			default: begin
				r.cell_data = screen[py * COLUMNS + px];
			end
		endcase
		r.cursor_col = COL_W'(csr_x);
		r.cursor_row = ROW_W'(csr_y);
		return r;
	endfunction

	task automatic send_request(input kind_t k, input logic [7:0] c,
		input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= k;
		req_ch.character <= c;
		req_ch.col       <= x;
		req_ch.row       <= y;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic write_attribute(input logic [7:0] v);
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		attr_byte = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : rsp_stall
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 2) begin
				hold = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		report_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("response transfer with nothing pending");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (rsp_ch.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp_ch.cursor_col);
					mismatches++;
				end
				if (rsp_ch.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_ch.cursor_row);
					mismatches++;
				end
				if (rsp_ch.cell_data !== want.cell_data) begin
					$error("cell_data: expected %04h, got %04h", want.cell_data, rsp_ch.cell_data);
					mismatches++;
				end
				if (rsp_ch.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", want.scrolled, rsp_ch.scrolled);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		kind_t            k;
		logic [7:0]       c;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic [7:0]       attr_v;
		int               roll;
		report_t          r;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 8'h00;
		req_ch.valid     = 1'b0;
		req_ch.kind      = KIND_PRINT;
		req_ch.character = 8'h00;
		req_ch.col       = '0;
		req_ch.row       = '0;
		rsp_ch.ready     = 1'b0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = '0;
		csr_x     = 0;
		csr_y     = 0;
		attr_byte = ATTR_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].is_cfg) begin
				write_attribute(SCRIPT[i].attr);
			end else begin
				send_request(SCRIPT[i].kind, SCRIPT[i].ch, SCRIPT[i].col, SCRIPT[i].row);
				r = console_step(SCRIPT[i].kind, SCRIPT[i].ch, SCRIPT[i].col, SCRIPT[i].row);
				pending_reports.push_back(SCRIPT[i].typed ? SCRIPT[i].want : r);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			attr_v = (p == 2 || p == 3) ? 8'($urandom_range(0, 255)) : PHASE_ATTR[p];
			write_attribute(attr_v);
			gap_pct = PHASE_GAP[p];
			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				c = 8'($urandom_range(0, 255));
				x = COL_W'($urandom_range(0, 127));
				y = ROW_W'($urandom_range(0, 31));
				if (roll < 2) begin
					k = KIND_CLEAR;
				end else if (roll < 14) begin
					k = KIND_SETPOS;
				end else if (roll < 36) begin
					k = KIND_READ;
					// bias reads toward the row being written
					if (roll < 26)
						y = ROW_W'(csr_y);
				end else begin
					k = KIND_PRINT;
					roll = $urandom_range(0, 99);
					if (roll < 8)
						c = CH_NEWLINE;
					else if (roll < 12)
						c = CH_RETURN;
					else if (roll < 20)
						c = CH_BACKSPACE;
				end
				send_request(k, c, x, y);
				pending_reports.push_back(console_step(k, c, x, y));
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_store.sv
design/text_console_writer.sv
dv/tb_top.sv
